// File: rtl/core/template_match_metric_defines.svh
// Assertion macros for the template match metric block.
// Included by the top level only; no other dependencies.
`ifndef TEMPLATE_MATCH_METRIC_DEFINES_SVH
`define TEMPLATE_MATCH_METRIC_DEFINES_SVH

`ifndef SYNTHESIS
// Condition holds in the same cycle as the trigger
`define TMM_ASSERT_IMPL(lbl, clk, rst_n, trig, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (expr)) \
        else $error("template_match_metric: assertion failed");
// Condition holds in the cycle after the trigger
`define TMM_ASSERT_NEXT(lbl, clk, rst_n, trig, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (expr)) \
        else $error("template_match_metric: assertion failed");
`else
`define TMM_ASSERT_IMPL(lbl, clk, rst_n, trig, expr)
`define TMM_ASSERT_NEXT(lbl, clk, rst_n, trig, expr)
`endif

`endif

// File: rtl/core/tmm_pkg.sv
// Shared types and constants for the template match metric block.
// No dependencies.
`timescale 1ns / 1ps

package tmm_pkg;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 13;
    localparam int DIFF_W  = 13;
    localparam int CNT_W   = 5;
    localparam int DIV_CNT_W = $clog2(DIFF_W + 1);

    localparam logic [PIX_W-1:0] MISSING_PENALTY = 8'hFF;
    localparam logic [PIX_W-1:0] NO_VALID_AVG    = 8'hFF;

    // Totals of one finished run, handed from front to back
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DIFF_W-1:0]  diff;
        logic [CNT_W-1:0]   valid_cnt;
        logic [CNT_W-1:0]   match_cnt;
    } run_sum_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

endpackage

// File: rtl/core/tmm_front.sv
// Front part: scores one position per item and builds the run totals.
// Depends on tmm_pkg.
`timescale 1ns / 1ps

module tmm_front #(
    parameter int TEMPLATE_SIZE = 21
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [tmm_pkg::PIX_W-1:0]    s_cur_value,
    input  logic                         s_cur_valid,
    input  logic [tmm_pkg::PIX_W-1:0]    s_cand_value,
    input  logic                         s_cand_valid,
    input  logic [tmm_pkg::COORD_W-1:0]  s_cand_x,
    input  logic [tmm_pkg::COORD_W-1:0]  s_cand_y,
    output logic                         push_valid,
    input  logic                         push_ready,
    output tmm_pkg::run_sum_t            push_data
);

    localparam logic [tmm_pkg::CNT_W-1:0] LAST_POS = tmm_pkg::CNT_W'(TEMPLATE_SIZE - 1);

    logic [tmm_pkg::CNT_W-1:0]   pos_reg,    pos_next;
    logic [tmm_pkg::DIFF_W-1:0]  diff_reg,   diff_next;
    logic [tmm_pkg::CNT_W-1:0]   valid_reg,  valid_next;
    logic [tmm_pkg::CNT_W-1:0]   match_reg,  match_next;
    logic                        stop_reg,   stop_next;
    logic [tmm_pkg::COORD_W-1:0] x_reg,      x_next;
    logic [tmm_pkg::COORD_W-1:0] y_reg,      y_next;

    logic                        first;
    logic                        last;
    logic                        accept;
    logic [tmm_pkg::PIX_W-1:0]   abs_diff;
    logic [tmm_pkg::PIX_W-1:0]   add_val;
    logic [tmm_pkg::DIFF_W-1:0]  diff_base;
    logic [tmm_pkg::CNT_W-1:0]   valid_base;
    logic [tmm_pkg::CNT_W-1:0]   match_base;
    logic                        stop_base;

    assign first  = (pos_reg == '0);
    assign last   = (pos_reg == LAST_POS);
    // Only the last item of a run needs room in the queue
    assign s_ready = !last || push_ready;
    assign accept  = s_valid && s_ready;

    // Absolute difference and the amount to add at this position
    assign abs_diff = (s_cur_value >= s_cand_value) ? (s_cur_value - s_cand_value)
                                                    : (s_cand_value - s_cur_value);
    assign add_val  = s_cand_valid ? abs_diff : tmm_pkg::MISSING_PENALTY;

    // Position 0 starts from cleared totals
    assign diff_base  = first ? '0 : diff_reg;
    assign valid_base = first ? '0 : valid_reg;
    assign match_base = first ? '0 : match_reg;
    assign stop_base  = first ? 1'b0 : stop_reg;

    // Scoring of the current position
    always_comb begin
        diff_next  = diff_base;
        valid_next = valid_base;
        match_next = match_base;
        stop_next  = stop_base;
        if (!stop_base) begin
            if (s_cur_valid) begin
                valid_next = valid_base + 1'b1;
                diff_next  = diff_base + tmm_pkg::DIFF_W'(add_val);
                if (s_cand_valid && (abs_diff == '0)) begin
                    match_next = match_base + 1'b1;
                end
            end
            if (match_next < pos_reg) begin
                stop_next = 1'b1;
            end
        end
        x_next   = first ? s_cand_x : x_reg;
        y_next   = first ? s_cand_y : y_reg;
        pos_next = last ? '0 : (pos_reg + 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (accept) begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            diff_reg  <= diff_next;
            valid_reg <= valid_next;
            match_reg <= match_next;
            stop_reg  <= stop_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
        end
    end

    // Run totals go to the queue with the last item
    assign push_valid          = s_valid && last;
    assign push_data.x         = x_next;
    assign push_data.y         = y_next;
    assign push_data.diff      = diff_next;
    assign push_data.valid_cnt = valid_next;
    assign push_data.match_cnt = match_next;

endmodule

// File: rtl/core/tmm_queue.sv
// Two-entry queue of run totals between the front and back parts.
// Depends on tmm_pkg.
`timescale 1ns / 1ps

module tmm_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  tmm_pkg::run_sum_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output tmm_pkg::run_sum_t rd_data
);

    tmm_pkg::run_sum_t entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg,  count_next;
    logic              do_push;
    logic              do_pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_push  = wr_valid && wr_ready;
    assign do_pop   = rd_valid && rd_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/core/tmm_back.sv
// Back part: bit-serial divide of the run total and the result register.
// Depends on tmm_pkg.
`timescale 1ns / 1ps

module tmm_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  tmm_pkg::run_sum_t            q_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tmm_pkg::COORD_W-1:0]  m_match_x,
    output logic [tmm_pkg::COORD_W-1:0]  m_match_y,
    output logic [tmm_pkg::PIX_W-1:0]    m_avg_abs_diff,
    output logic [tmm_pkg::CNT_W-1:0]    m_valid_points,
    output logic [tmm_pkg::CNT_W-1:0]    m_match_points
);

    localparam logic [tmm_pkg::DIV_CNT_W-1:0] DIV_STEPS =
        tmm_pkg::DIV_CNT_W'(tmm_pkg::DIFF_W);

    tmm_pkg::div_state_t state_reg, state_next;

    tmm_pkg::run_sum_t               sum_reg;
    logic [tmm_pkg::DIFF_W-1:0]      quo_reg,  quo_next;
    logic [tmm_pkg::CNT_W-1:0]       rem_reg,  rem_next;
    logic [tmm_pkg::DIV_CNT_W-1:0]   step_reg, step_next;
    logic                            m_valid_reg, m_valid_next;

    logic [tmm_pkg::COORD_W-1:0]     x_reg, y_reg;
    logic [tmm_pkg::PIX_W-1:0]       avg_reg;
    logic [tmm_pkg::CNT_W-1:0]       vpts_reg, mpts_reg;

    logic                            load;
    logic                            step;
    logic                            finish;
    logic                            out_free;
    logic [tmm_pkg::CNT_W:0]         shifted;
    logic [tmm_pkg::CNT_W:0]         trial;
    logic                            fits;

    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tmm_pkg::DIV_IDLE: begin
                if (q_valid) begin
                    state_next = tmm_pkg::DIV_RUN;
                end
            end
            tmm_pkg::DIV_RUN: begin
                if (step_reg == tmm_pkg::DIV_CNT_W'(1)) begin
                    state_next = tmm_pkg::DIV_DONE;
                end
            end
            tmm_pkg::DIV_DONE: begin
                if (out_free) begin
                    state_next = tmm_pkg::DIV_IDLE;
                end
            end
            default: begin
                state_next = tmm_pkg::DIV_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        load   = 1'b0;
        step   = 1'b0;
        finish = 1'b0;
        case (state_reg)
            tmm_pkg::DIV_IDLE: load   = q_valid;
            tmm_pkg::DIV_RUN:  step   = 1'b1;
            tmm_pkg::DIV_DONE: finish = out_free;
            default: begin
                load = 1'b0;
            end
        endcase
    end

    assign q_ready = load;

    // One restoring divide step: one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[tmm_pkg::DIFF_W-1]};
    assign trial   = shifted - {1'b0, sum_reg.valid_cnt};
    assign fits    = (shifted >= {1'b0, sum_reg.valid_cnt});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        if (load) begin
            quo_next  = q_data.diff;
            rem_next  = '0;
            step_next = DIV_STEPS;
        end else if (step) begin
            quo_next  = {quo_reg[tmm_pkg::DIFF_W-2:0], fits};
            rem_next  = fits ? trial[tmm_pkg::CNT_W-1:0] : shifted[tmm_pkg::CNT_W-1:0];
            step_next = step_reg - 1'b1;
        end
    end

    // Result register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tmm_pkg::DIV_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        if (load) begin
            sum_reg <= q_data;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (finish) begin
            x_reg    <= sum_reg.x;
            y_reg    <= sum_reg.y;
            avg_reg  <= (sum_reg.valid_cnt == '0) ? tmm_pkg::NO_VALID_AVG
                                                  : quo_reg[tmm_pkg::PIX_W-1:0];
            vpts_reg <= sum_reg.valid_cnt;
            mpts_reg <= sum_reg.match_cnt;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_match_x      = x_reg;
    assign m_match_y      = y_reg;
    assign m_avg_abs_diff = avg_reg;
    assign m_valid_points = vpts_reg;
    assign m_match_points = mpts_reg;

endmodule

// File: rtl/core/template_match_metric.sv
// Top level of the template match metric block.
// Depends on tmm_pkg, tmm_front, tmm_queue, tmm_back and the defines header.
`timescale 1ns / 1ps
`include "template_match_metric_defines.svh"

// Usage
//   s_* channel: one item per neighbour position, TEMPLATE_SIZE items per run
//   in fixed order; s_cand_x / s_cand_y are taken on the first item only.
//   m_* channel: one result per run, after its last item.
//   Input rate: one item per cycle. Scoring is a single add per item in the
//   front stage; s_ready drops only on a run's last item while the two-entry
//   run queue is full.
//   After a run's last item is taken, its totals pass through the run queue,
//   are loaded into the divider, go through the one-bit-per-cycle divider and
//   are then written into the result register.
//   The divider takes a new run only from its idle state, one run at a time,
//   so short runs can be paced by the divider.
//   When m_ready is low, the result register holds, the divider waits with
//   its quotient, and the queue absorbs up to two more runs before s_ready
//   drops.
//   Reset (aresetn low, synchronous) empties the queue and the result
//   register and starts a new run at position 0.
module template_match_metric #(
    parameter int TEMPLATE_SIZE = 21
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [tmm_pkg::PIX_W-1:0]    s_cur_value,
    input  logic                         s_cur_valid,
    input  logic [tmm_pkg::PIX_W-1:0]    s_cand_value,
    input  logic                         s_cand_valid,
    input  logic [tmm_pkg::COORD_W-1:0]  s_cand_x,
    input  logic [tmm_pkg::COORD_W-1:0]  s_cand_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tmm_pkg::COORD_W-1:0]  m_match_x,
    output logic [tmm_pkg::COORD_W-1:0]  m_match_y,
    output logic [tmm_pkg::PIX_W-1:0]    m_avg_abs_diff,
    output logic [tmm_pkg::CNT_W-1:0]    m_valid_points,
    output logic [tmm_pkg::CNT_W-1:0]    m_match_points
);

    logic              push_valid;
    logic              push_ready;
    tmm_pkg::run_sum_t push_data;
    tmm_pkg::run_sum_t q_data;
    logic              q_valid;
    logic              q_ready;

    // Front: per-position scoring
    tmm_front #(
        .TEMPLATE_SIZE (TEMPLATE_SIZE)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cur_value  (s_cur_value),
        .s_cur_valid  (s_cur_valid),
        .s_cand_value (s_cand_value),
        .s_cand_valid (s_cand_valid),
        .s_cand_x     (s_cand_x),
        .s_cand_y     (s_cand_y),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    // Queue of finished run totals
    tmm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    // Back: divide and result register
    tmm_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_data         (q_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_match_x      (m_match_x),
        .m_match_y      (m_match_y),
        .m_avg_abs_diff (m_avg_abs_diff),
        .m_valid_points (m_valid_points),
        .m_match_points (m_match_points)
    );

    // Checks
    `TMM_ASSERT_IMPL(a_match_le_valid, aclk, aresetn, m_valid, m_match_points <= m_valid_points)
    `TMM_ASSERT_IMPL(a_valid_le_size, aclk, aresetn, m_valid, m_valid_points <= TEMPLATE_SIZE)
    `TMM_ASSERT_IMPL(a_empty_avg, aclk, aresetn, m_valid && (m_valid_points == '0), m_avg_abs_diff == tmm_pkg::NO_VALID_AVG)
    `TMM_ASSERT_NEXT(a_push_lands, aclk, aresetn, push_valid && push_ready, q_valid)

endmodule
